/* rtl/pti_pkg.sv */
`timescale 1ns / 1ps
// shared types, sizes and status codes of the pointing table interpolator
// no dependencies

package pti_pkg;

    localparam int SOURCE_COUNT  = 64;
    localparam int TABLE_ENTRIES = 32;

    localparam int SRC_AW = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W = $clog2(SOURCE_COUNT * TABLE_ENTRIES);
    localparam int FRAC_W = 16;
    localparam int DCNT_W = $clog2(FRAC_W + 1);

    localparam logic [2:0] ST_INTERP = 3'd0;
    localparam logic [2:0] ST_EXACT  = 3'd1;
    localparam logic [2:0] ST_STORED = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_RANGE  = 3'd4;

    localparam logic       OP_STORE = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic signed [33:0] QUARTER_TURN = 34'sh040000000;
    localparam logic signed [33:0] FULL_TURN    = 34'sh100000000;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         source_id;
        logic [23:0]        sample_time;
        logic [31:0]        store_az;
        logic signed [31:0] store_el;
        logic [31:0]        store_ha;
        logic signed [31:0] store_dec;
    } t_in;

    typedef struct packed {
        logic [31:0]        out_az;
        logic signed [31:0] out_el;
        logic [31:0]        out_ha;
        logic signed [31:0] out_dec;
        logic [2:0]         status;
    } t_out;

    typedef struct packed {
        logic [23:0] tstamp;
        logic [31:0] az;
        logic [31:0] el;
        logic [31:0] ha;
        logic [31:0] dec;
    } t_row;

    typedef struct packed {
        logic              en;
        logic [SRC_AW-1:0] src;
        logic [CNT_W-1:0]  val;
    } t_cnt_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_RD,
        S_CNT,
        S_ROW_RD,
        S_ROW,
        S_WRITE,
        S_DIV,
        S_DIV_WAIT,
        S_MAC,
        S_MAC_WAIT,
        S_DONE
    } t_state;

endpackage

/* rtl/pointing_table_interpolator_unit.sv */
`timescale 1ns / 1ps
// top level of the pointing table interpolator: sequencer, result register
// depends on pti_pkg, pti_tbl, pti_cnt, pti_div, pti_mac

// One beat in, one result beat out. A store does a fill count read, a read
// of the last stored entry to check the time order, then the write; a store
// into an empty table skips the entry read, and a store into a full table
// ends right after the count read. A query scans its source's table from the
// first entry with one registered memory read per entry; an interpolation
// then adds the one-bit-per-cycle fraction divider and three passes of the
// shared multiply-round unit (azimuth, elevation, hour angle). The block
// takes one beat at a time and is ready again once the result sits in the
// output register.

module pointing_table_interpolator_unit
    import pti_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_in,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_out
);

    t_state            r_state, n_state;
    t_in               r_in;
    logic [CNT_W-1:0]  r_n;
    logic [IDX_W-1:0]  r_idx;
    t_row              r_prev, r_next;
    t_out              r_res;
    t_out              r_out;
    logic              r_ovalid;
    logic [1:0]        r_ang;
    logic [FRAC_W-1:0] r_frac;

    logic [SRC_AW-1:0] src;
    logic              src_bad;
    logic [ADDR_W-1:0] base;
    logic [CNT_W-1:0]  cnt_now;
    t_row              rd_row;
    t_row              wr_row;
    t_cnt_wr           cnt_wr;
    logic              tbl_we;
    logic              div_start, div_done;
    logic [FRAC_W-1:0] div_q;
    logic              mac_start, mac_done, mac_wrap;
    logic [31:0]       mac_a0, mac_a1, mac_res;
    logic              out_load;
    logic              is_store;
    logic              row_ge, row_eq;

    assign src      = SRC_AW'(r_in.source_id);
    assign src_bad  = 32'(r_in.source_id) >= SOURCE_COUNT;
    assign base     = ADDR_W'(32'(src) * TABLE_ENTRIES);
    assign is_store = r_in.opcode == OP_STORE;
    assign row_ge   = rd_row.tstamp >= r_in.sample_time;
    assign row_eq   = rd_row.tstamp == r_in.sample_time;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_ready);

    assign wr_row = '{tstamp: r_in.sample_time, az: r_in.store_az, el: r_in.store_el,
                      ha: r_in.store_ha, dec: r_in.store_dec};

    pti_tbl u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (base + ADDR_W'(r_n)),
        .i_wrow  (wr_row),
        .i_raddr (base + ADDR_W'(r_idx)),
        .o_rrow  (rd_row)
    );

    pti_cnt u_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cnt_wr),
        .i_raddr (src),
        .o_count (cnt_now)
    );

    pti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_in.sample_time - r_prev.tstamp),
        .i_den   (r_next.tstamp - r_prev.tstamp),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        case (r_ang)
            2'd0: begin
                mac_a0 = r_prev.az; mac_a1 = r_next.az; mac_wrap = 1'b1;
            end
            2'd1: begin
                mac_a0 = r_prev.el; mac_a1 = r_next.el; mac_wrap = 1'b0;
            end
            default: begin
                mac_a0 = r_prev.ha; mac_a1 = r_next.ha; mac_wrap = 1'b1;
            end
        endcase
    end

    pti_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_wrap  (mac_wrap),
        .i_a0    (mac_a0),
        .i_a1    (mac_a1),
        .i_frac  (r_frac),
        .o_done  (mac_done),
        .o_res   (mac_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_valid) n_state = S_CNT_RD;
            S_CNT_RD:   n_state = S_CNT;
            S_CNT: begin
                if (src_bad) begin
                    n_state = S_DONE;
                end else if (is_store) begin
                    if (32'(cnt_now) >= TABLE_ENTRIES) n_state = S_DONE;
                    else if (cnt_now == '0)            n_state = S_WRITE;
                    else                               n_state = S_ROW_RD;
                end else begin
                    n_state = (cnt_now == '0) ? S_DONE : S_ROW_RD;
                end
            end
            S_ROW_RD:   n_state = S_ROW;
            S_ROW: begin
                if (is_store) begin
                    n_state = row_ge ? S_DONE : S_WRITE;
                end else if (row_ge) begin
                    n_state = (row_eq || r_idx == '0) ? S_DONE : S_DIV;
                end else begin
                    n_state = (CNT_W'(r_idx) == r_n - 1'b1) ? S_DONE : S_ROW_RD;
                end
            end
            S_WRITE:    n_state = S_DONE;
            S_DIV:      n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (div_done) n_state = S_MAC;
            S_MAC:      n_state = S_MAC_WAIT;
            S_MAC_WAIT: if (mac_done) n_state = (r_ang == 2'd2) ? S_DONE : S_MAC;
            S_DONE:     if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        o_ready   = r_state == S_IDLE;
        tbl_we    = r_state == S_WRITE;
        div_start = r_state == S_DIV;
        mac_start = r_state == S_MAC;
        cnt_wr    = '{en: r_state == S_WRITE, src: src, val: r_n + 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load)     r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_in  <= i_in;
                    r_res <= '{out_az: '0, out_el: '0, out_ha: '0, out_dec: '0,
                               status: ST_RANGE};
                end
            end
            S_CNT: begin
                r_n   <= cnt_now;
                r_idx <= is_store ? IDX_W'(cnt_now - 1'b1) : '0;
                if (!src_bad && is_store && 32'(cnt_now) >= TABLE_ENTRIES) begin
                    r_res.status <= ST_FULL;
                end
            end
            S_ROW: begin
                r_next <= rd_row;
                if (!is_store && row_eq) begin
                    r_res <= '{out_az: rd_row.az, out_el: rd_row.el, out_ha: rd_row.ha,
                               out_dec: rd_row.dec, status: ST_EXACT};
                end
                if (!row_ge) begin
                    r_prev <= rd_row;
                    r_idx  <= r_idx + 1'b1;
                end
            end
            S_WRITE: r_res.status <= ST_STORED;
            S_DIV_WAIT: begin
                r_frac <= div_q;
                r_ang  <= 2'd0;
            end
            S_MAC_WAIT: begin
                if (mac_done) begin
                    r_ang <= r_ang + 1'b1;
                    case (r_ang)
                        2'd0:    r_res.out_az <= mac_res;
                        2'd1:    r_res.out_el <= mac_res;
                        default: begin
                            r_res.out_ha  <= mac_res;
                            r_res.out_dec <= r_next.dec;
                            r_res.status  <= ST_INTERP;
                        end
                    endcase
                end
            end
            S_DONE: if (out_load) r_out <= r_res;
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.status == ST_STORED || o_out.status == ST_FULL ||
                    o_out.status == ST_RANGE)
        |-> (o_out.out_az == '0 && o_out.out_el == '0 && o_out.out_ha == '0 &&
             o_out.out_dec == '0))
        else $error("non-interpolated result carries angle data");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> 32'(r_n) < TABLE_ENTRIES)
        else $error("write into a full table");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROW |-> CNT_W'(r_idx) < r_n)
        else $error("scan past fill count");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV_WAIT)
        else $error("divider finished outside its wait state");

endmodule

/* rtl/pti_tbl.sv */
`timescale 1ns / 1ps
// sample table memory for all sources, one write and one registered read port
// depends on pti_pkg

module pti_tbl
    import pti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_row              i_wrow,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_row              o_rrow
);

    t_row r_mem [SOURCE_COUNT*TABLE_ENTRIES];
    t_row r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wrow;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rrow = r_q;

endmodule

/* rtl/pti_cnt.sv */
`timescale 1ns / 1ps
// per-source fill counts: small memory plus reset-cleared valid bits
// depends on pti_pkg

module pti_cnt
    import pti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cnt_wr           i_wr,
    input  logic [SRC_AW-1:0] i_raddr,
    output logic [CNT_W-1:0]  o_count
);

    logic [CNT_W-1:0]        r_mem [SOURCE_COUNT];
    logic [SOURCE_COUNT-1:0] r_vld;
    logic [CNT_W-1:0]        r_q;
    logic                    r_qv;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.src] <= i_wr.val;
        end
        r_q <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.src] <= 1'b1;
            end
            r_qv <= r_vld[i_raddr];
        end
    end

    // never-written source reads as empty
    assign o_count = r_qv ? r_q : '0;

endmodule

/* rtl/pti_div.sv */
`timescale 1ns / 1ps
// restoring divider for the interpolation fraction, one quotient bit a cycle
// depends on pti_pkg

module pti_div
    import pti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [23:0]       i_num,
    input  logic [23:0]       i_den,
    output logic              o_done,
    output logic [FRAC_W-1:0] o_quot
);

    logic [23:0]       r_rem;
    logic [23:0]       r_den;
    logic [FRAC_W-1:0] r_quot;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [24:0]       shifted;
    logic              take;

    // numerator is below the denominator, so the quotient fits the fraction
    assign shifted = {r_rem, 1'b0};
    assign take    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? 24'(shifted - {1'b0, r_den}) : shifted[23:0];
            r_quot <= {r_quot[FRAC_W-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/pti_mac.sv */
`timescale 1ns / 1ps
// shared angle interpolation unit: difference, multiply by fraction, round, add
// depends on pti_pkg

module pti_mac
    import pti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_wrap,
    input  logic [31:0]       i_a0,
    input  logic [31:0]       i_a1,
    input  logic [FRAC_W-1:0] i_frac,
    output logic              o_done,
    output logic [31:0]       o_res
);

    logic signed [33:0] d_raw;
    logic signed [33:0] d;
    logic signed [50:0] prod;
    logic signed [50:0] r_prod;
    logic [31:0]        r_a0;
    logic signed [50:0] rounded;
    logic [31:0]        r_res;
    logic               r_stage;
    logic               r_done;

    always_comb begin
        if (i_wrap) begin
            d_raw = $signed({2'b00, i_a1}) - $signed({2'b00, i_a0});
        end else begin
            d_raw = $signed({{2{i_a1[31]}}, i_a1}) - $signed({{2{i_a0[31]}}, i_a0});
        end
        d = d_raw;
        // on a wrapping angle, a difference beyond a quarter turn either way is moved by a full turn
        if (i_wrap && (d_raw > QUARTER_TURN)) begin
            d = d_raw - FULL_TURN;
        end else if (i_wrap && (d_raw < -QUARTER_TURN)) begin
            d = d_raw + FULL_TURN;
        end
    end

    assign prod    = d * $signed({1'b0, i_frac});
    assign rounded = (r_prod + 51'sd32768) >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= prod;
            r_a0   <= i_a0;
        end
        if (r_stage) begin
            r_res <= r_a0 + rounded[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
